[hdl/jsrl_pkg.sv]
// shared types and constants for the joint slew rate limiter
package jsrl_pkg;

    // fixed field widths
    localparam int OP_BITS    = 2;
    localparam int JOINT_BITS = 6;
    localparam int STEP_BITS  = 12;

    // the sensed-angle window is this many step limits wide on each side
    localparam int SENSOR_FACTOR = 6;

    // operation codes; the last one is unused and ignored
    typedef enum logic [OP_BITS-1:0] {
        OP_LIMIT     = 2'd0,
        OP_LOAD_STEP = 2'd1,
        OP_SEED      = 2'd2,
        OP_RESERVED  = 2'd3
    } t_op;

endpackage

[hdl/joint_slew_rate_limiter_top.sv]
// per-joint slew rate limiter: state memories, two clamps and output register
//
// channel  | handshake           | payload
// ---------+---------------------+----------------------------------------------
// input    | i_valid / o_ready   | i_op, i_joint, i_commanded_angle,
//          |                     | i_sensed_angle, i_step_value
// output   | o_valid / i_ready   | o_joint_out, o_limited_angle, o_was_limited
//
// one beat per cycle sustained while the output is not stalled; a limit command
// shows at the output after the input and memory read register, then the result register.
// a command to the joint written by the beat just ahead is served by a bypass.
// reset clears the valid bits of both state memories, so every joint reads as
// zero last angle and zero step limit at once, with no clearing pass.
// an output stall holds the result register; the input keeps taking beats
// until the stage ahead of the result register is also full.
module joint_slew_rate_limiter_top #(
    parameter int JOINT_COUNT = 22,
    parameter int ANGLE_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [jsrl_pkg::OP_BITS-1:0]           i_op,
    input  logic [jsrl_pkg::JOINT_BITS-1:0]        i_joint,
    input  logic signed [ANGLE_BITS-1:0]           i_commanded_angle,
    input  logic signed [ANGLE_BITS-1:0]           i_sensed_angle,
    input  logic [jsrl_pkg::STEP_BITS-1:0]         i_step_value,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [jsrl_pkg::JOINT_BITS-1:0]        o_joint_out,
    output logic signed [ANGLE_BITS-1:0]           o_limited_angle,
    output logic                                   o_was_limited
);

    localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    // wide enough for sensed angle plus six full step limits
    localparam int CW    = ((ANGLE_BITS > 15) ? ANGLE_BITS : 15) + 3;
    localparam longint SAT_HI_L = (longint'(1) << (ANGLE_BITS - 1)) - 1;
    localparam logic signed [CW-1:0] SAT_HI = CW'(SAT_HI_L);
    localparam logic signed [CW-1:0] SAT_LO = CW'(-SAT_HI_L - 1);

    // state memories and their valid bits
    logic signed [ANGLE_BITS-1:0]          mem_last [JOINT_COUNT];
    logic [jsrl_pkg::STEP_BITS-1:0]        mem_step [JOINT_COUNT];
    logic [JOINT_COUNT-1:0]                r_last_vld;
    logic [JOINT_COUNT-1:0]                r_step_vld;

    // work stage registers
    logic                                  r_b_valid;
    jsrl_pkg::t_op                         r_op;
    logic                                  r_op_ok;
    logic [jsrl_pkg::JOINT_BITS-1:0]       r_joint;
    logic signed [ANGLE_BITS-1:0]          r_cmd;
    logic signed [ANGLE_BITS-1:0]          r_sensed;
    logic [jsrl_pkg::STEP_BITS-1:0]        r_step_in;
    logic signed [ANGLE_BITS-1:0]          r_last_rd;
    logic [jsrl_pkg::STEP_BITS-1:0]        r_step_rd;
    logic                                  r_last_rd_vld;
    logic                                  r_step_rd_vld;
    logic                                  r_last_hit;
    logic                                  r_step_hit;
    logic signed [ANGLE_BITS-1:0]          r_last_fwd;
    logic [jsrl_pkg::STEP_BITS-1:0]        r_step_fwd;

    // result registers
    logic                                  r_o_valid;
    logic [jsrl_pkg::JOINT_BITS-1:0]       r_o_joint;
    logic signed [ANGLE_BITS-1:0]          r_o_angle;
    logic                                  r_o_limited;

    logic                                  accept;
    logic                                  in_range;
    logic [IDX_W-1:0]                      in_idx;
    logic [IDX_W-1:0]                      b_idx;
    logic                                  b_range;
    logic                                  b_result;
    logic                                  b_done;
    logic                                  wr_last;
    logic                                  wr_step;
    logic signed [ANGLE_BITS-1:0]          wr_last_data;
    logic signed [ANGLE_BITS-1:0]          last_cur;
    logic [jsrl_pkg::STEP_BITS-1:0]        step_cur;
    logic signed [CW-1:0]                  last_x;
    logic signed [CW-1:0]                  cmd_x;
    logic signed [CW-1:0]                  sensed_x;
    logic signed [CW-1:0]                  step_x;
    logic signed [CW-1:0]                  step6_x;
    logic signed [CW-1:0]                  lo1;
    logic signed [CW-1:0]                  hi1;
    logic signed [CW-1:0]                  lo2;
    logic signed [CW-1:0]                  hi2;
    logic signed [CW-1:0]                  v1;
    logic signed [CW-1:0]                  v2;
    logic signed [CW-1:0]                  v3;
    logic                                  moved;
    logic                                  n_o_valid;

    // input handshake
    assign in_range = (int'(i_joint) < JOINT_COUNT);
    assign in_idx   = i_joint[IDX_W-1:0];
    assign accept   = i_valid && o_ready;
    assign o_ready  = !r_b_valid || b_done;

    // work stage control
    assign b_idx    = r_joint[IDX_W-1:0];
    assign b_range  = (int'(r_joint) < JOINT_COUNT);
    assign b_result = r_b_valid && b_range && r_op_ok && (r_op == jsrl_pkg::OP_LIMIT);
    assign b_done   = r_b_valid && (!b_result || !r_o_valid || i_ready);

    // current state of the joint, with bypass from the beat just ahead
    always_comb begin
        if (r_last_hit) begin
            last_cur = r_last_fwd;
        end else if (r_last_rd_vld) begin
            last_cur = r_last_rd;
        end else begin
            last_cur = '0;
        end
        if (r_step_hit) begin
            step_cur = r_step_fwd;
        end else if (r_step_rd_vld) begin
            step_cur = r_step_rd;
        end else begin
            step_cur = '0;
        end
    end

    // two clamps at full width, then saturation
    always_comb begin
        last_x   = {{(CW-ANGLE_BITS){last_cur[ANGLE_BITS-1]}}, last_cur};
        cmd_x    = {{(CW-ANGLE_BITS){r_cmd[ANGLE_BITS-1]}}, r_cmd};
        sensed_x = {{(CW-ANGLE_BITS){r_sensed[ANGLE_BITS-1]}}, r_sensed};
        step_x   = {{(CW-jsrl_pkg::STEP_BITS){1'b0}}, step_cur};
        step6_x  = CW'(step_x * CW'(jsrl_pkg::SENSOR_FACTOR));
        lo1      = last_x - step_x;
        hi1      = last_x + step_x;
        lo2      = sensed_x - step6_x;
        hi2      = sensed_x + step6_x;
        moved    = 1'b0;
        if (cmd_x < lo1) begin
            v1    = lo1;
            moved = 1'b1;
        end else if (cmd_x > hi1) begin
            v1    = hi1;
            moved = 1'b1;
        end else begin
            v1 = cmd_x;
        end
        if (v1 < lo2) begin
            v2    = lo2;
            moved = 1'b1;
        end else if (v1 > hi2) begin
            v2    = hi2;
            moved = 1'b1;
        end else begin
            v2 = v1;
        end
        if (v2 > SAT_HI) begin
            v3 = SAT_HI;
        end else if (v2 < SAT_LO) begin
            v3 = SAT_LO;
        end else begin
            v3 = v2;
        end
    end

    // state writes when the work stage retires
    always_comb begin
        wr_last      = 1'b0;
        wr_step      = 1'b0;
        wr_last_data = v3[ANGLE_BITS-1:0];
        if (b_done && b_range && r_op_ok) begin
            unique case (r_op)
                jsrl_pkg::OP_LIMIT: begin
                    wr_last = 1'b1;
                end
                jsrl_pkg::OP_LOAD_STEP: begin
                    wr_step = 1'b1;
                end
                jsrl_pkg::OP_SEED: begin
                    wr_last      = 1'b1;
                    wr_last_data = r_sensed;
                end
                default: begin
                    wr_last = 1'b0;
                end
            endcase
        end
    end

    // memory write ports
    always_ff @(posedge i_clk) begin
        if (wr_last) begin
            mem_last[b_idx] <= wr_last_data;
        end
        if (wr_step) begin
            mem_step[b_idx] <= r_step_in;
        end
    end

    // memory read ports, registered with the beat
    always_ff @(posedge i_clk) begin
        if (accept && in_range) begin
            r_last_rd <= mem_last[in_idx];
            r_step_rd <= mem_step[in_idx];
        end
    end

    // valid bits of both memories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_vld <= '0;
            r_step_vld <= '0;
        end else begin
            if (wr_last) begin
                r_last_vld[b_idx] <= 1'b1;
            end
            if (wr_step) begin
                r_step_vld[b_idx] <= 1'b1;
            end
        end
    end

    // work stage payload, valid flags and bypass capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op          <= jsrl_pkg::t_op'(i_op);
            r_op_ok       <= (i_op != jsrl_pkg::OP_RESERVED);
            r_joint       <= i_joint;
            r_cmd         <= i_commanded_angle;
            r_sensed      <= i_sensed_angle;
            r_step_in     <= i_step_value;
            r_last_rd_vld <= in_range && r_last_vld[in_idx];
            r_step_rd_vld <= in_range && r_step_vld[in_idx];
            r_last_hit    <= wr_last && (r_joint == i_joint);
            r_step_hit    <= wr_step && (r_joint == i_joint);
            r_last_fwd    <= wr_last_data;
            r_step_fwd    <= r_step_in;
        end
    end

    // work stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (accept) begin
            r_b_valid <= 1'b1;
        end else if (b_done) begin
            r_b_valid <= 1'b0;
        end
    end

    // result register
    always_comb begin
        n_o_valid = r_o_valid;
        if (b_done && b_result) begin
            n_o_valid = 1'b1;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_done && b_result) begin
            r_o_joint   <= r_joint;
            r_o_angle   <= v3[ANGLE_BITS-1:0];
            r_o_limited <= moved;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_joint_out     = r_o_joint;
    assign o_limited_angle = r_o_angle;
    assign o_was_limited   = r_o_limited;

endmodule
